// ===== src/icymd_pkg.sv =====
`timescale 1ns / 1ps

package icymd_pkg;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_TITLE = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_AUDIO = 2'd0,
        PH_META  = 2'd1
    } phase_t;

    typedef enum logic [1:0] {
        TP_BEFORE = 2'd0,
        TP_IN     = 2'd1,
        TP_DONE   = 2'd2
    } title_phase_t;

    localparam int INTERVAL_W = 24;
    localparam int META_LEFT_W = 12;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [3:0] META_UNIT_PAD = 4'h0;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } parse_out_t;

endpackage

// ===== src/icymd_if.sv =====
`timescale 1ns / 1ps

interface icymd_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface icymd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface icymd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] meta_interval;

    modport source (output valid, output meta_interval, input ready);
    modport sink (input valid, input meta_interval, output ready);
endinterface

// ===== src/icymd_parse.sv =====
`timescale 1ns / 1ps

module icymd_parse
    import icymd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic [INTERVAL_W-1:0]  cfg_data,
    input  logic                   consume,
    input  logic [7:0]             data_byte,
    output parse_out_t             res
);

    logic [INTERVAL_W-1:0]  interval_reg;
    phase_t                 phase_reg, phase_next;
    logic [INTERVAL_W-1:0]  audio_left_reg, audio_left_next;
    logic [META_LEFT_W-1:0] meta_left_reg, meta_left_next;
    title_phase_t           tp_reg, tp_next;
    logic                   seen_reg, seen_next;

    always_comb
    begin
        phase_next = phase_reg;
        audio_left_next = audio_left_reg;
        meta_left_next = meta_left_reg;
        tp_next = tp_reg;
        seen_next = seen_reg;
        res = '0;

        if (interval_reg == '0)
        begin
            res.count = 2'd1;
            res.r0.out_byte = data_byte;
            res.r0.kind = KIND_AUDIO;
        end
        else if (phase_reg == PH_AUDIO)
        begin
            if (audio_left_reg != '0)
            begin
                res.count = 2'd1;
                res.r0.out_byte = data_byte;
                res.r0.kind = KIND_AUDIO;
                audio_left_next = audio_left_reg - 1'b1;
            end
            else if (data_byte == 8'd0)
            begin
                audio_left_next = interval_reg;
            end
            else
            begin
                meta_left_next = {data_byte, META_UNIT_PAD};
                tp_next = TP_BEFORE;
                seen_next = 1'b0;
                phase_next = PH_META;
            end
        end
        else
        begin
            meta_left_next = meta_left_reg - 1'b1;
            case (tp_reg)
                TP_BEFORE:
                begin
                    if (data_byte == CH_EQUALS)
                    begin
                        tp_next = TP_IN;
                    end
                end
                TP_IN:
                begin
                    if (data_byte == CH_SEMI)
                    begin
                        tp_next = TP_DONE;
                        if (seen_reg)
                        begin
                            res.count = 2'd1;
                            res.r0.out_byte = 8'd0;
                            res.r0.kind = KIND_END;
                        end
                    end
                    else
                    begin
                        res.count = 2'd1;
                        res.r0.out_byte = data_byte;
                        res.r0.kind = KIND_TITLE;
                        seen_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // The block ends here: close an open, non-empty title.
            if (meta_left_next == '0)
            begin
                if (tp_next == TP_IN && seen_next)
                begin
                    if (res.count == 2'd0)
                    begin
                        res.r0.out_byte = 8'd0;
                        res.r0.kind = KIND_END;
                    end
                    else
                    begin
                        res.r1.out_byte = 8'd0;
                        res.r1.kind = KIND_END;
                    end
                    res.count = res.count + 2'd1;
                end
                tp_next = TP_DONE;
                phase_next = PH_AUDIO;
                audio_left_next = interval_reg;
            end
        end

        if (res.count == 2'd1)
        begin
            res.r0.last = 1'b1;
        end
        else if (res.count == 2'd2)
        begin
            res.r1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= '0;
            phase_reg <= PH_AUDIO;
            audio_left_reg <= '0;
            meta_left_reg <= '0;
            tp_reg <= TP_BEFORE;
            seen_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            interval_reg <= cfg_data;
            phase_reg <= PH_AUDIO;
            audio_left_reg <= cfg_data;
            meta_left_reg <= '0;
            tp_reg <= TP_BEFORE;
            seen_reg <= 1'b0;
        end
        else if (consume && interval_reg != '0)
        begin
            phase_reg <= phase_next;
            audio_left_reg <= audio_left_next;
            meta_left_reg <= meta_left_next;
            tp_reg <= tp_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== src/icymd_resq.sv =====
`timescale 1ns / 1ps

module icymd_resq
    import icymd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  parse_out_t             push_word,
    output logic                   room,
    icymd_result_if.source         result
);

    localparam int DEPTH = 4;

    result_t    ent_reg [DEPTH];
    result_t    ent_next [DEPTH];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_n;
    logic       pop;

    assign push_n = push_en ? push_word.count : 2'd0;
    assign pop = result.valid && result.ready;
    assign room = (count_reg <= 3'd2);

    assign result.valid = (count_reg != 3'd0);
    assign result.out_byte = ent_reg[rd_ptr_reg].out_byte;
    assign result.kind = ent_reg[rd_ptr_reg].kind;
    assign result.last = ent_reg[rd_ptr_reg].last;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
            if (push_n != 2'd0 && wr_ptr_reg == 2'(i))
            begin
                ent_next[i] = push_word.r0;
            end
            if (push_n == 2'd2 && (wr_ptr_reg + 2'd1) == 2'(i))
            begin
                ent_next[i] = push_word.r1;
            end
        end
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/icy_metadata_demux_top.sv =====
`timescale 1ns / 1ps

// Splits a streaming-radio body into audio words and title words.
// The stream channel takes one body byte per word. The result channel
// gives out_byte, kind (audio, title or end of title) and last, which marks
// the final result caused by one input word. The cfg channel writes the
// metadata interval and restarts framing; it is always ready. It is to be
// written only while the block is idle; the block does not enforce this.
// An accepted byte waits in the input register until the queue has room,
// is parsed into a four-entry result queue, and its results are offered
// from the queue register. One byte is accepted every cycle while the
// queue has room; a byte that yields two results takes two entries.
// When the receiver stalls, the queue fills and the stream channel drops
// ready once the queue holds three or more results. Reset clears the
// interval to zero (pass-through), empties the queue and resets the framing.
module icy_metadata_demux_top
    import icymd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    icymd_stream_if.sink   stream,
    icymd_cfg_if.sink      cfg,
    icymd_result_if.source result
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       consume;
    logic       room;
    logic       cfg_wr;
    parse_out_t parse_res;

    assign consume = in_valid_reg && room;
    assign stream.ready = !in_valid_reg || consume;
    assign cfg.ready = 1'b1;
    assign cfg_wr = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.data_byte;
        end
    end

    icymd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg.meta_interval),
        .consume   (consume),
        .data_byte (in_byte_reg),
        .res       (parse_res)
    );

    icymd_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (consume),
        .push_word (parse_res),
        .room      (room),
        .result    (result)
    );

endmodule

// ===== src/icymd_checker.sv =====
`timescale 1ns / 1ps

module icymd_checker
    import icymd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_byte,
    input logic [1:0] res_kind,
    input logic       res_last
);

    // A result that is offered stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_kind != 2'd3)
        else $error("undefined result kind");

    // The end-of-title marker carries a zero byte and closes its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_END |-> res_byte == 8'd0 && res_last)
        else $error("malformed end-of-title marker");

    // Audio words are always the only result of their input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_AUDIO |-> res_last)
        else $error("audio result not marked last");

endmodule

bind icy_metadata_demux_top icymd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_byte  (result.out_byte),
    .res_kind  (result.kind),
    .res_last  (result.last)
);
